>>> src/sdspi_pkg.sv
// Package for the SD SPI transaction engine: result kinds, phases, CRC steps.
// No dependencies.
package sdspi_pkg;

    localparam int BlockBytesDefault = 512;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_CARD  = 2'd1,
        OP_WDATA = 2'd2,
        OP_BAD   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        K_TX     = 4'd0,
        K_R1     = 4'd1,
        K_WORD   = 4'd2,
        K_RBYTE  = 4'd3,
        K_RDOK   = 4'd4,
        K_CRCERR = 4'd5,
        K_BADTOK = 4'd6,
        K_REJECT = 4'd7,
        K_OOS    = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        TK_R1    = 2'd0,
        TK_WORD  = 2'd1,
        TK_READ  = 2'd2,
        TK_WRITE = 2'd3
    } t_xfer;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WR1   = 7'b0000010,
        PH_WORD  = 7'b0000100,
        PH_HUNT  = 7'b0001000,
        PH_RDATA = 7'b0010000,
        PH_RCRC  = 7'b0100000,
        PH_WDAT  = 7'b1000000
    } t_phase;

    localparam logic [7:0] CmdBase  = 8'h40;
    localparam logic [7:0] FillByte = 8'hff;
    localparam logic [7:0] TokByte  = 8'hfe;
    localparam logic [7:0] Crc7Poly = 8'h12;

    // One result group: up to six results, count and payload of each.
    typedef struct packed {
        logic [2:0]        count;
        logic [5:0][3:0]   kind;
        logic [5:0][7:0]   bval;
        logic [31:0]       wval;
        logic [8:0]        idx;
    } t_group;

    function automatic logic [7:0] crc7_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ Crc7Poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [7:0] x;
        x = crc[15:8] ^ d;
        x = x ^ (x >> 4);
        return (crc << 8) ^ ({8'd0, x} << 12) ^ ({8'd0, x} << 5) ^ {8'd0, x};
    endfunction

endpackage

>>> src/sdspi_if.sv
// Valid/ready channel interfaces for the SD SPI engine.
// Depends on nothing.
interface sdspi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  transfer_kind;
    logic [7:0]  data_byte;
    modport source (output valid, opcode, cmd_index, argument, transfer_kind, data_byte,
                    input ready);
    modport sink (input valid, opcode, cmd_index, argument, transfer_kind, data_byte,
                  output ready);
endinterface

interface sdspi_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] word_value;
    logic [8:0]  byte_index;
    logic        last;
    modport source (output valid, kind, byte_value, word_value, byte_index, last,
                    input ready);
    modport sink (input valid, kind, byte_value, word_value, byte_index, last,
                  output ready);
endinterface

>>> src/sdspi_front.sv
// Front part: parse each word against the transaction state and build its result group.
// Depends on sdspi_pkg.
module sdspi_front #(
    parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_block_addressing,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_cmd_index,
    input  logic [31:0]        i_argument,
    input  logic [1:0]         i_transfer_kind,
    input  logic [7:0]         i_data_byte,
    output logic               o_push,
    output sdspi_pkg::t_group  o_group,
    input  logic               i_full
);
    import sdspi_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_pend, n_pend;
    logic [9:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic [31:0] r_word, n_word;
    t_group      g;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && (g.count != 3'd0);
    assign o_group = g;

    always_comb begin
        logic [31:0] arg;
        logic [7:0]  c7;
        logic [9:0]  cnt1;
        logic [15:0] crcn;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_word  = r_word;
        g       = '0;
        cnt1    = r_cnt + 10'd1;
        crcn    = crc16_step(r_crc, i_data_byte);
        arg     = i_argument;
        c7      = '0;
        if (i_transfer_kind[1] && !i_block_addressing) arg = {i_argument[22:0], 9'd0};
        if (i_opcode == OP_CMD) begin
            g.count = 3'd6;
            g.bval[0] = CmdBase | {2'b00, i_cmd_index};
            g.bval[1] = arg[31:24];
            g.bval[2] = arg[23:16];
            g.bval[3] = arg[15:8];
            g.bval[4] = arg[7:0];
            for (int i = 0; i < 5; i++) c7 = crc7_step(c7, g.bval[i]);
            g.bval[5] = c7 | 8'h01;
            n_phase = PH_WR1;
            n_pend  = i_transfer_kind;
            n_cnt   = '0;
            n_crc   = '0;
            n_word  = '0;
        end else if (i_opcode == OP_CARD && r_phase == PH_WR1) begin
            if (i_data_byte != FillByte) begin
                g.count = 3'd1;
                g.kind[0] = K_R1;
                g.bval[0] = i_data_byte;
                n_cnt = '0; n_crc = '0; n_word = '0;
                if (r_pend == TK_R1) n_phase = PH_IDLE;
                else if (r_pend == TK_WORD) n_phase = PH_WORD;
                else if (i_data_byte != 8'd0) begin
                    g.count = 3'd2;
                    g.kind[1] = K_REJECT;
                    n_phase = PH_IDLE;
                end else if (r_pend == TK_READ) n_phase = PH_HUNT;
                else begin
                    g.count = 3'd3;
                    g.bval[1] = FillByte;
                    g.bval[2] = TokByte;
                    n_phase = PH_WDAT;
                end
            end
        end else if (i_opcode == OP_CARD && r_phase == PH_WORD) begin
            n_word = {r_word[23:0], i_data_byte};
            n_cnt  = cnt1;
            if (cnt1 >= 10'd4) begin
                g.count = 3'd1; g.kind[0] = K_WORD; g.wval = n_word;
                n_phase = PH_IDLE; n_cnt = '0;
            end
        end else if (i_opcode == OP_CARD && r_phase == PH_HUNT) begin
            if (i_data_byte == TokByte) begin
                n_phase = PH_RDATA; n_cnt = '0; n_crc = '0;
            end else if (i_data_byte != FillByte) begin
                g.count = 3'd1; g.kind[0] = K_BADTOK; g.bval[0] = i_data_byte;
                n_phase = PH_IDLE;
            end
        end else if (i_opcode == OP_CARD && r_phase == PH_RDATA) begin
            g.count = 3'd1; g.kind[0] = K_RBYTE; g.bval[0] = i_data_byte;
            g.idx = r_cnt[8:0];
            n_crc = crcn; n_cnt = cnt1;
            if (cnt1 >= 10'(BLOCK_BYTES)) begin
                n_phase = PH_RCRC; n_cnt = '0;
            end
        end else if (i_opcode == OP_CARD && r_phase == PH_RCRC) begin
            n_crc = crcn; n_cnt = cnt1;
            if (cnt1 >= 10'd2) begin
                g.count = 3'd1;
                g.kind[0] = (crcn == 16'd0) ? K_RDOK : K_CRCERR;
                n_phase = PH_IDLE; n_cnt = '0;
            end
        end else if (i_opcode == OP_WDATA && r_phase == PH_WDAT) begin
            n_crc = crcn; n_cnt = cnt1;
            g.count = 3'd1; g.bval[0] = i_data_byte;
            if (cnt1 >= 10'(BLOCK_BYTES)) begin
                g.count = 3'd4;
                g.bval[1] = crcn[15:8];
                g.bval[2] = crcn[7:0];
                g.bval[3] = FillByte;
                n_phase = PH_IDLE; n_cnt = '0;
            end
        end else begin
            g.count = 3'd1; g.kind[0] = K_OOS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_crc   <= '0;
            r_word  <= '0;
        end else if (i_valid && !i_full) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_word  <= n_word;
        end
    end
endmodule

>>> src/sdspi_back.sv
// Back part: group queue and serializer handing out one result word per cycle while i_ready is high.
// Depends on sdspi_pkg.
module sdspi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sdspi_pkg::t_group i_group,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_kind,
    output logic [7:0]        o_byte_value,
    output logic [31:0]       o_word_value,
    output logic [8:0]        o_byte_index,
    output logic              o_last
);
    import sdspi_pkg::*;

    t_group     r_q [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic [2:0] r_pos;
    logic       pop, take;
    t_group     head;

    assign head    = r_q[r_rp];
    assign o_full  = (r_fill == 2'(QueueDepth));
    assign o_valid = (r_fill != 2'd0);
    assign take    = o_valid && i_ready;
    assign o_last  = (r_pos == head.count - 3'd1);
    assign pop     = take && o_last;
    assign o_kind  = head.kind[r_pos];
    assign o_byte_value = head.bval[r_pos];
    assign o_word_value = head.wval;
    assign o_byte_index = head.idx;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0; r_pos <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_fill <= r_fill + 2'(i_push) - 2'(pop);
            if (pop) r_pos <= '0;
            else if (take) r_pos <= r_pos + 3'd1;
        end
    end
endmodule

>>> src/sd_spi_transaction_engine.sv
// Top level of the SD SPI transaction engine.
// Depends on sdspi_pkg, sdspi_if, sdspi_front, sdspi_back.
//
// One input word per cycle is accepted while the two-entry group queue has
// room; each word yields zero to six result words, delivered one per cycle
// while the output is ready; a command yields six transmit bytes, and card
// data bytes stream at one per cycle likewise. The front parser keeps the
// transaction state; the back serializer drains queued result groups.
module sd_spi_transaction_engine #(
    parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    sdspi_in_if.sink    in_ch,
    sdspi_out_if.source out_ch
);
    import sdspi_pkg::*;

    logic   r_block_addressing;
    logic   push, full;
    t_group grp;

    // Hold the addressing mode until rewritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_block_addressing <= 1'b0;
        else if (i_cfg_we) r_block_addressing <= i_cfg_data;
    end

    sdspi_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_block_addressing(r_block_addressing),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_opcode(in_ch.opcode), .i_cmd_index(in_ch.cmd_index),
        .i_argument(in_ch.argument), .i_transfer_kind(in_ch.transfer_kind),
        .i_data_byte(in_ch.data_byte),
        .o_push(push), .o_group(grp), .i_full(full)
    );

    sdspi_back u_back (
        .i_clk, .i_rst_n,
        .i_push(push), .i_group(grp), .o_full(full),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_kind(out_ch.kind), .o_byte_value(out_ch.byte_value),
        .o_word_value(out_ch.word_value), .o_byte_index(out_ch.byte_index),
        .o_last(out_ch.last)
    );
endmodule

>>> src/sdspi_checker.sv
// Port-level checker for the SD SPI engine, bound to the top level.
// Depends on sdspi_pkg and sdspi_if.
module sdspi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_kind,
    input logic [7:0]  out_byte_value,
    input logic [31:0] out_word_value,
    input logic        out_last
);
    import sdspi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte_value))
        else $error("stalled result word changed");
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_kind != K_WORD |-> out_word_value == 32'd0)
        else $error("word value on non-word result");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_kind <= K_OOS)
        else $error("bad result kind");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && (out_kind == K_REJECT || out_kind == K_OOS || out_kind == K_WORD)
        |-> out_last)
        else $error("status result not last");
endmodule

bind sd_spi_transaction_engine sdspi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.kind), .out_byte_value(out_ch.byte_value),
    .out_word_value(out_ch.word_value), .out_last(out_ch.last)
);

>>> test/sdspi_test_if.sv
`timescale 1ns / 1ps
// Test-side constants for the SD SPI engine testbench.
// Depends on nothing; the channel interfaces come from src/sdspi_if.sv.
package sdspi_test_pkg;
    localparam int WatchdogLimit = 20000;
endpackage

>>> test/sd_spi_transaction_engine_test.sv
`timescale 1ns / 1ps
// Testbench for sd_spi_transaction_engine: random and directed SD SPI traffic.
// Depends on sdspi_pkg, sdspi_if and sdspi_test_pkg; predicts results in-line.
module sd_spi_transaction_engine_test;
    import sdspi_pkg::*;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [1:0]  transfer_kind;
        logic [7:0]  data_byte;
    } t_word_in;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] word_value;
        logic [8:0]  byte_index;
        logic        last;
    } t_word_out;

    // predictor phase codes
    typedef enum logic [2:0] {
        S_IDLE, S_WR1, S_WORD, S_HUNT, S_RDATA, S_RCRC, S_WDAT
    } t_sd_state;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    sdspi_in_if  in_ch ();
    sdspi_out_if out_ch ();

    sd_spi_transaction_engine dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    t_word_in  pending_words[$];
    t_word_out expected_results[$];
    int        mismatch_count;
    int        stall_pct;
    int        idle_cycles;
    bit        stimulus_done;

    // predictor state
    logic       blk_addr;
    t_sd_state  sd_state;
    logic [1:0] pend_xfer;
    logic [9:0] byte_cnt;
    logic [15:0] crc16_acc;
    logic [31:0] word_acc;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] next_crc7(logic [7:0] crc, logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ 8'h12) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] next_crc16(logic [15:0] crc, logic [7:0] d);
        logic [15:0] x;
        x = {8'd0, crc[15:8] ^ d};
        x = x ^ (x >> 4);
        return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
    endfunction

    task automatic push_result(t_kind k, logic [7:0] b, logic [31:0] w, logic [8:0] idx);
        t_word_out r;
        r.kind = k;
        r.byte_value = b;
        r.word_value = w;
        r.byte_index = idx;
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    // Advance the transaction model by one accepted word; queue its results.
    task automatic predict_results(t_word_in w);
        logic [31:0] a;
        logic [7:0]  cb[5];
        logic [7:0]  c7;
        int          base_count;
        base_count = expected_results.size();
        if (w.opcode == OP_CMD) begin
            a = w.argument;
            if (w.transfer_kind >= TK_READ && !blk_addr) a = a << 9;
            cb[0] = CmdBase | {2'b00, w.cmd_index};
            cb[1] = a[31:24]; cb[2] = a[23:16]; cb[3] = a[15:8]; cb[4] = a[7:0];
            c7 = 8'h00;
            for (int i = 0; i < 5; i++) begin
                push_result(K_TX, cb[i], 0, 0);
                c7 = next_crc7(c7, cb[i]);
            end
            push_result(K_TX, c7 | 8'h01, 0, 0);
            sd_state = S_WR1;
            pend_xfer = w.transfer_kind;
            byte_cnt = 0; crc16_acc = 0; word_acc = 0;
        end else if (w.opcode == OP_CARD && sd_state == S_WR1) begin
            if (w.data_byte != FillByte) begin
                push_result(K_R1, w.data_byte, 0, 0);
                byte_cnt = 0; crc16_acc = 0; word_acc = 0;
                if (pend_xfer == TK_R1) sd_state = S_IDLE;
                else if (pend_xfer == TK_WORD) sd_state = S_WORD;
                else if (w.data_byte != 0) begin
                    push_result(K_REJECT, 0, 0, 0);
                    sd_state = S_IDLE;
                end else if (pend_xfer == TK_READ) sd_state = S_HUNT;
                else begin
                    push_result(K_TX, FillByte, 0, 0);
                    push_result(K_TX, TokByte, 0, 0);
                    sd_state = S_WDAT;
                end
            end
        end else if (w.opcode == OP_CARD && sd_state == S_WORD) begin
            word_acc = {word_acc[23:0], w.data_byte};
            byte_cnt++;
            if (byte_cnt >= 4) begin
                push_result(K_WORD, 0, word_acc, 0);
                sd_state = S_IDLE;
                byte_cnt = 0;
            end
        end else if (w.opcode == OP_CARD && sd_state == S_HUNT) begin
            if (w.data_byte == TokByte) begin
                sd_state = S_RDATA; byte_cnt = 0; crc16_acc = 0;
            end else if (w.data_byte != FillByte) begin
                push_result(K_BADTOK, w.data_byte, 0, 0);
                sd_state = S_IDLE;
            end
        end else if (w.opcode == OP_CARD && sd_state == S_RDATA) begin
            push_result(K_RBYTE, w.data_byte, 0, byte_cnt[8:0]);
            crc16_acc = next_crc16(crc16_acc, w.data_byte);
            byte_cnt++;
            if (byte_cnt >= 512) begin
                sd_state = S_RCRC; byte_cnt = 0;
            end
        end else if (w.opcode == OP_CARD && sd_state == S_RCRC) begin
            crc16_acc = next_crc16(crc16_acc, w.data_byte);
            byte_cnt++;
            if (byte_cnt >= 2) begin
                push_result(crc16_acc == 0 ? K_RDOK : K_CRCERR, 0, 0, 0);
                sd_state = S_IDLE; byte_cnt = 0;
            end
        end else if (w.opcode == OP_WDATA && sd_state == S_WDAT) begin
            crc16_acc = next_crc16(crc16_acc, w.data_byte);
            push_result(K_TX, w.data_byte, 0, 0);
            byte_cnt++;
            if (byte_cnt >= 512) begin
                push_result(K_TX, crc16_acc[15:8], 0, 0);
                push_result(K_TX, crc16_acc[7:0], 0, 0);
                push_result(K_TX, FillByte, 0, 0);
                sd_state = S_IDLE; byte_cnt = 0;
            end
        end else begin
            push_result(K_OOS, 0, 0, 0);
        end
        if (expected_results.size() > base_count)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Driver: hold the word until it is taken, then advance to the next.
    always @(posedge i_clk) begin
        t_word_in w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                w = {in_ch.opcode, in_ch.cmd_index, in_ch.argument, in_ch.transfer_kind,
                     in_ch.data_byte};
                predict_results(w);
                void'(pending_words.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready) ) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= stall_pct) begin
                    w = pending_words[0];
                    in_ch.valid <= 1'b1;
                    {in_ch.opcode, in_ch.cmd_index, in_ch.argument, in_ch.transfer_kind,
                     in_ch.data_byte} <= w;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_word_out e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result kind", out_ch.kind, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.kind != e.kind) report_mismatch("kind", out_ch.kind, e.kind);
                    if (out_ch.byte_value != e.byte_value)
                        report_mismatch("byte_value", out_ch.byte_value, e.byte_value);
                    if (out_ch.word_value != e.word_value)
                        report_mismatch("word_value", out_ch.word_value, e.word_value);
                    if (out_ch.byte_index != e.byte_index)
                        report_mismatch("byte_index", out_ch.byte_index, e.byte_index);
                    if (out_ch.last != e.last) report_mismatch("last", out_ch.last, e.last);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= sdspi_test_pkg::WatchdogLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic t_word_in mk(logic [1:0] op, logic [5:0] ci, logic [31:0] arg,
                                    logic [1:0] tk, logic [7:0] b);
        t_word_in w;
        w.opcode = op; w.cmd_index = ci; w.argument = arg;
        w.transfer_kind = tk; w.data_byte = b;
        return w;
    endfunction

    function automatic t_word_in card(logic [7:0] b);
        return mk(OP_CARD, $urandom, $urandom, $urandom, b);
    endfunction

    task automatic queue_cmd(logic [1:0] tk);
        pending_words.push_back(mk(OP_CMD, $urandom, $urandom, tk, $urandom));
    endtask

    // Open a write and send the first n data bytes of its block.
    task automatic queue_write(int n);
        queue_cmd(TK_WRITE);
        pending_words.push_back(card(8'h00));
        for (int i = 0; i < n; i++)
            pending_words.push_back(mk(OP_WDATA, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic queue_random_mix(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            if (sel < 3) begin
                queue_cmd($urandom);
                pending_words.push_back(card($urandom_range(1) ? 8'h00 : $urandom));
                if ($urandom_range(1))
                    repeat (4) pending_words.push_back(card($urandom));
            end else if (sel < 5) begin
                queue_cmd(TK_WORD);
                pending_words.push_back(card(FillByte));
                pending_words.push_back(card($urandom_range(1)));
                repeat (4) pending_words.push_back(card($urandom));
            end else if (sel < 7) begin
                queue_cmd(TK_READ);
                pending_words.push_back(card(8'h00));
                pending_words.push_back(card($urandom));
                pending_words.push_back(card($urandom));
            end else begin
                pending_words.push_back(mk($urandom, $urandom, $urandom, $urandom,
                                           $urandom));
            end
        end
    endtask

    // Drain everything outstanding, then let the pipe settle.
    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        blk_addr = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.cmd_index = '0;
        in_ch.argument = '0;
        in_ch.transfer_kind = '0;
        in_ch.data_byte = '0;
        out_ch.ready = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        stall_pct = 24;
        blk_addr = 1'b0;
        sd_state = S_IDLE;
        pend_xfer = 0; byte_cnt = 0; crc16_acc = 0; word_acc = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every opcode, out-of-sequence, reject, bad token.
        pending_words.push_back(card(8'h00));
        pending_words.push_back(mk(OP_WDATA, 0, 0, 0, 8'hff));
        pending_words.push_back(mk(OP_BAD, 6'h3f, 32'hffffffff, 2'd3, 8'hff));
        pending_words.push_back(mk(OP_CMD, 6'h00, 32'h00000000, TK_R1, 0));
        pending_words.push_back(card(FillByte));
        pending_words.push_back(card(8'h01));
        pending_words.push_back(mk(OP_CMD, 6'h3f, 32'hffffffff, TK_WORD, 0));
        pending_words.push_back(card(8'h01));
        pending_words.push_back(card(8'hff));
        pending_words.push_back(card(8'h00));
        pending_words.push_back(card(8'haa));
        pending_words.push_back(card(8'h55));
        pending_words.push_back(mk(OP_CMD, 6'h11, 32'hffffffff, TK_READ, 0));
        pending_words.push_back(card(8'h04));
        pending_words.push_back(mk(OP_CMD, 6'h18, 32'h80000001, TK_WRITE, 0));
        pending_words.push_back(card(8'hfe));
        pending_words.push_back(mk(OP_CMD, 6'h11, 32'h00000001, TK_READ, 0));
        pending_words.push_back(card(8'h00));
        pending_words.push_back(card(8'hff));
        pending_words.push_back(card(8'h0b));
        pending_words.push_back(mk(OP_CMD, 6'h08, 32'h1aa, TK_WORD, 0));
        pending_words.push_back(mk(OP_CMD, 6'h18, 32'h1, TK_WRITE, 0));
        pending_words.push_back(card(8'h00));
        pending_words.push_back(card(8'h00));
        wait_drained();
        pending_words.delete();
        queue_write(8);
        // abandon the open write so the next phase starts cleanly
        pending_words.push_back(mk(OP_CMD, 0, 0, TK_R1, 0));
        pending_words.push_back(card(8'h00));
        queue_random_mix(25);
        wait_drained();

        write_cfg(1'b1);
        stall_pct = 0;
        queue_random_mix(25);
        wait_drained();
        stall_pct = 24;
        queue_random_mix(25);
        wait_drained();

        write_cfg(1'b0);
        queue_random_mix(25);
        wait_drained();

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
